[hw/rtl/acl_pkg.sv]
`timescale 1ns / 1ps

package acl_pkg;

	// Table geometry.
	localparam int MAX_ENTRIES = 16;
	localparam int ID_BITS     = 16;
	localparam int PERM_W      = 4;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ENTRIES);

	// Permission bits.
	localparam logic [PERM_W-1:0] PERM_ALL   = 4'hF;
	localparam int                PERM_SHARE = 2;

	// Request kinds.
	localparam logic [1:0] KIND_CHECK  = 2'd0;
	localparam logic [1:0] KIND_GRANT  = 2'd1;
	localparam logic [1:0] KIND_REVOKE = 2'd2;

	// Status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_DENIED    = 3'd2;
	localparam logic [2:0] ST_INVALID   = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic [ID_BITS-1:0] user;
		logic [ID_BITS-1:0] granter;
		logic [PERM_W-1:0]  perms;
	} acl_entry_t;

	localparam int ENTRY_W = $bits(acl_entry_t);

endpackage

[hw/rtl/acl_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module acl_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 36,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/delegated_acl_table_core.sv]
`timescale 1ns / 1ps

// Delegated access-control table.
// Requests arrive on the in_valid / in_ready channel as kind, actor_id, subject_id
// and perm_bits; each request yields exactly one status on the out_valid / out_ready
// channel, in request order. The owner id is written through the cfg channel, which
// is always ready and must only be used while no request is in flight.
// The table sits in a small RAM with one read and one write port. A single id
// comparator walks the valid entries, one entry per cycle, under a sequencer; the
// block takes one request at a time and is not ready while that request is worked.
// Work done per request:
//   a check makes at most one search, a grant up to two (a grantor search and a
//   subject search), and a revoke at most a search that stops at the entry and
//   then a pass that moves the later entries down one place. Every search reads
//   the entries through the single RAM read port. The block is ready for the
//   next request in the same cycle that its status is presented.
// A finished status waits in an output register; a new request is taken while it
// waits, but the next status is held back until the receiver has taken the last.
// Reset empties the table (the entry count goes to zero) and sets the owner to 1.
module delegated_acl_table_core
	import acl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [ID_BITS-1:0] actor_id,
	input  logic [ID_BITS-1:0] subject_id,
	input  logic [PERM_W-1:0]  perm_bits,

	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [ID_BITS-1:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_GRANT,
		S_SCAN,
		S_EVAL,
		S_SHIFT,
		S_RESP
	} state_t;

	// Which id the current scan is looking for.
	typedef enum logic {
		PH_ACTOR,
		PH_SUBJ
	} phase_t;

	state_t             state_q;
	phase_t             phase_q;
	logic [1:0]         kind_q;
	logic [ID_BITS-1:0] actor_q;
	logic [ID_BITS-1:0] subj_q;
	logic [PERM_W-1:0]  perms_q;
	logic [PERM_W-1:0]  allowed_q;
	logic [ID_BITS-1:0] owner_q;
	logic [ID_BITS-1:0] key_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   scan_addr_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic               rd_pend_q;
	logic               found_q;
	logic [IDX_W-1:0]   hit_idx_q;
	acl_entry_t         hit_q;
	logic [2:0]         res_q;
	logic               out_valid_q;
	logic [2:0]         status_q;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	acl_entry_t         ram_wdata;
	logic               ram_re;
	acl_entry_t         ram_rdata;

	logic               issue;
	logic               hit;
	logic               eval_write;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign status    = status_q;

	// The scan and the shift pass both stream reads while entries remain.
	assign issue = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (scan_addr_q < count_q);

	// The shared comparator: the entry just read against the search key.
	assign hit = rd_pend_q && (ram_rdata.user == key_q);

	// A grant either rewrites the subject's entry or appends one if there is room.
	assign eval_write = (state_q == S_EVAL) && (kind_q == KIND_GRANT) &&
		(phase_q == PH_SUBJ) && (found_q || (count_q < MAX_COUNT));

	always_comb begin
		ram_re    = issue;
		ram_we    = 1'b0;
		ram_waddr = hit_idx_q;
		ram_wdata = '{user: subj_q, granter: actor_q, perms: perms_q};
		if (eval_write) begin
			ram_we    = 1'b1;
			ram_waddr = found_q ? hit_idx_q : count_q[IDX_W-1:0];
		end else if ((state_q == S_SHIFT) && rd_pend_q) begin
			// Each later entry moves down by one place.
			ram_we    = 1'b1;
			ram_waddr = rd_idx_q - IDX_W'(1);
			ram_wdata = ram_rdata;
		end
	end

	acl_ram #(
		.DEPTH(MAX_ENTRIES),
		.WIDTH(ENTRY_W),
		.AW   (IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(scan_addr_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_SUBJ;
			owner_q     <= ID_BITS'(1);
			count_q     <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				owner_q <= cfg_data;
			end

			// The response state sets the output itself when it hands over.
			if (out_valid_q && out_ready && (state_q != S_RESP)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q  <= kind;
						actor_q <= actor_id;
						subj_q  <= subject_id;
						perms_q <= perm_bits;
						state_q <= S_START;
					end
				end

				S_START: begin
					// Searches that follow always start from the first entry.
					scan_addr_q <= '0;
					rd_pend_q   <= 1'b0;
					// A grant by anyone but the owner first looks for the grantor.
					if ((kind_q == KIND_GRANT) && (actor_q != owner_q)) begin
						phase_q <= PH_ACTOR;
						key_q   <= actor_q;
					end else begin
						phase_q <= PH_SUBJ;
						key_q   <= subj_q;
					end
					case (kind_q)
						KIND_CHECK: begin
							if (subj_q == owner_q) begin
								res_q   <= ST_OK;
								state_q <= S_RESP;
							end else begin
								state_q <= S_SCAN;
							end
						end
						KIND_GRANT: begin
							if ((subj_q == '0) || (perms_q == '0)) begin
								res_q   <= ST_INVALID;
								state_q <= S_RESP;
							end else if (actor_q == owner_q) begin
								allowed_q <= PERM_ALL;
								state_q   <= S_GRANT;
							end else begin
								state_q <= S_SCAN;
							end
						end
						KIND_REVOKE: begin
							if (subj_q == owner_q) begin
								res_q   <= ST_DENIED;
								state_q <= S_RESP;
							end else begin
								state_q <= S_SCAN;
							end
						end
						default: begin
							res_q   <= ST_INVALID;
							state_q <= S_RESP;
						end
					endcase
				end

				S_GRANT: begin
					// The grantor's rights are known; now judge the subject.
					scan_addr_q <= '0;
					rd_pend_q   <= 1'b0;
					phase_q     <= PH_SUBJ;
					key_q       <= subj_q;
					if (subj_q == owner_q) begin
						res_q   <= ST_OK;
						state_q <= S_RESP;
					end else if ((perms_q & ~allowed_q) != '0) begin
						res_q   <= ST_DENIED;
						state_q <= S_RESP;
					end else begin
						state_q <= S_SCAN;
					end
				end

				S_SCAN: begin
					if (hit) begin
						found_q   <= 1'b1;
						hit_idx_q <= rd_idx_q;
						hit_q     <= ram_rdata;
						rd_pend_q <= 1'b0;
						state_q   <= S_EVAL;
					end else if (issue) begin
						rd_pend_q   <= 1'b1;
						rd_idx_q    <= scan_addr_q[IDX_W-1:0];
						scan_addr_q <= scan_addr_q + CNT_W'(1);
					end else if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
					end else begin
						found_q <= 1'b0;
						state_q <= S_EVAL;
					end
				end

				S_EVAL: begin
					case (kind_q)
						KIND_CHECK: begin
							state_q <= S_RESP;
							if (!found_q) begin
								res_q <= ST_NOT_FOUND;
							end else if ((hit_q.perms & perms_q) != perms_q) begin
								res_q <= ST_DENIED;
							end else begin
								res_q <= ST_OK;
							end
						end
						KIND_GRANT: begin
							if (phase_q == PH_ACTOR) begin
								if (!found_q) begin
									res_q   <= ST_NOT_FOUND;
									state_q <= S_RESP;
								end else if (!hit_q.perms[PERM_SHARE]) begin
									res_q   <= ST_DENIED;
									state_q <= S_RESP;
								end else begin
									allowed_q <= hit_q.perms;
									state_q   <= S_GRANT;
								end
							end else begin
								state_q <= S_RESP;
								if (found_q) begin
									res_q <= ST_OK;
								end else if (count_q < MAX_COUNT) begin
									count_q <= count_q + CNT_W'(1);
									res_q   <= ST_OK;
								end else begin
									res_q <= ST_FULL;
								end
							end
						end
						KIND_REVOKE: begin
							if (!found_q) begin
								res_q   <= ST_NOT_FOUND;
								state_q <= S_RESP;
							end else if ((actor_q != owner_q) && (actor_q != hit_q.granter)) begin
								res_q   <= ST_DENIED;
								state_q <= S_RESP;
							end else begin
								// Stream the entries after the hit down by one place.
								scan_addr_q <= {1'b0, hit_idx_q} + CNT_W'(1);
								rd_pend_q   <= 1'b0;
								state_q     <= S_SHIFT;
							end
						end
						default: begin
							res_q   <= ST_INVALID;
							state_q <= S_RESP;
						end
					endcase
				end

				S_SHIFT: begin
					if (issue) begin
						rd_pend_q   <= 1'b1;
						rd_idx_q    <= scan_addr_q[IDX_W-1:0];
						scan_addr_q <= scan_addr_q + CNT_W'(1);
					end else if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
					end else begin
						count_q <= count_q - CNT_W'(1);
						res_q   <= ST_OK;
						state_q <= S_RESP;
					end
				end

				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= res_q;
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The entry count never runs past the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_COUNT)
		else $error("entry count exceeds table size");

	// An accepted request always moves the sequencer out of idle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_START)
		else $error("accepted request did not start");

	// The table is only written while a grant is settled or a revoke compacts.
	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_EVAL) || (state_q == S_SHIFT))
		else $error("table written outside grant or revoke");

	// Compaction writes stay inside the valid part of the table.
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && (state_q == S_SHIFT) |-> {1'b0, ram_waddr} < count_q)
		else $error("compaction write beyond valid entries");

	// The count changes only when a grant appends or a revoke completes.
	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
			($past(state_q) == S_EVAL) || ($past(state_q) == S_SHIFT))
		else $error("entry count changed unexpectedly");

endmodule

[dv/delegated_acl_table_core_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the delegated access-control table. A clocked driver
// presents requests from a queue of pending items, and a clocked monitor keeps
// its own copy of the table. The monitor works out the status of every request it
// sees accepted and compares each returned status with the oldest one still owed.
module delegated_acl_table_core_tb;
	import acl_pkg::*;

	// The unused request code. It has no name in the package because the block
	// simply rejects it.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// Slowest run: about seven hundred requests, each with a scan or two of the table,
	// plus sender gaps and receiver stalls. The limit is several times that.
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_MAX  = 10;

	typedef struct {
		logic [1:0]         kind;
		logic [ID_BITS-1:0] actor;
		logic [ID_BITS-1:0] subject;
		logic [PERM_W-1:0]  perms;
		bit                 drain_first;
	} acl_request_t;

	typedef struct {
		acl_request_t req;
		logic [2:0]   status;
	} owed_status_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         kind = KIND_CHECK;
	logic [ID_BITS-1:0] actor_id = '0;
	logic [ID_BITS-1:0] subject_id = '0;
	logic [PERM_W-1:0]  perm_bits = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         status;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [ID_BITS-1:0] cfg_data = '0;

	// Requests waiting to be presented, and statuses still owed by the block.
	acl_request_t pending_reqs[$];
	owed_status_t owed_statuses[$];

	// The monitor's own copy of the table and of the owner register.
	acl_entry_t         shadow_table[MAX_ENTRIES];
	int                 shadow_used;
	logic [ID_BITS-1:0] shadow_owner;

	// The owner that the stimulus is currently written against.
	logic [ID_BITS-1:0] stim_owner = 16'd1;
	bit                 next_drain;

	int error_count;
	int cycle_count;
	int kinds_sent[4];
	int statuses_seen[8];
	int owner_writes;

	delegated_acl_table_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.actor_id  (actor_id),
		.subject_id(subject_id),
		.perm_bits (perm_bits),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Table model
	// ------------------------------------------------------------------

	// Index of the first entry that holds the user, or -1 when there is none.
	function automatic int find_user(logic [ID_BITS-1:0] who);
		for (int i = 0; i < shadow_used; i++) begin
			if (shadow_table[i].user == who)
				return i;
		end
		return -1;
	endfunction

	// Works out the status of one request and applies its effect to the
	// shadow table.
	function automatic logic [2:0] acl_outcome(acl_request_t req);
		int                slot;
		int                grantor_slot;
		logic [PERM_W-1:0] allowed;
		case (req.kind)
			KIND_CHECK: begin
				// The owner needs no entry at all.
				if (req.subject == shadow_owner)
					return ST_OK;
				slot = find_user(req.subject);
				if (slot < 0)
					return ST_NOT_FOUND;
				if ((shadow_table[slot].perms & req.perms) != req.perms)
					return ST_DENIED;
				return ST_OK;
			end
			KIND_GRANT: begin
				if (req.subject == '0 || req.perms == '0)
					return ST_INVALID;
				if (req.actor == shadow_owner) begin
					allowed = PERM_ALL;
				end else begin
					grantor_slot = find_user(req.actor);
					if (grantor_slot < 0)
						return ST_NOT_FOUND;
					if (!shadow_table[grantor_slot].perms[PERM_SHARE])
						return ST_DENIED;
					allowed = shadow_table[grantor_slot].perms;
				end
				// A grant to the owner is accepted but changes nothing.
				if (req.subject == shadow_owner)
					return ST_OK;
				// A grantor may not hand on a right that it lacks itself.
				if ((req.perms & allowed) != req.perms)
					return ST_DENIED;
				slot = find_user(req.subject);
				if (slot < 0) begin
					if (shadow_used >= MAX_ENTRIES)
						return ST_FULL;
					slot = shadow_used;
					shadow_used++;
				end
				shadow_table[slot].user    = req.subject;
				shadow_table[slot].granter = req.actor;
				shadow_table[slot].perms   = req.perms;
				return ST_OK;
			end
			KIND_REVOKE: begin
				if (req.subject == shadow_owner)
					return ST_DENIED;
				slot = find_user(req.subject);
				if (slot < 0)
					return ST_NOT_FOUND;
				if (req.actor != shadow_owner && req.actor != shadow_table[slot].granter)
					return ST_DENIED;
				// Later entries move down one place and keep their order.
				for (int i = slot; i + 1 < shadow_used; i++)
					shadow_table[i] = shadow_table[i + 1];
				shadow_used--;
				return ST_OK;
			end
			default: begin
				return ST_INVALID;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Driver: bursts of requests with random gaps. A request flagged to drain
	// first is held back until every owed status has come home.
	// ------------------------------------------------------------------
	int           burst_left;
	int           gap_left;
	acl_request_t next_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() != 0 &&
					(!pending_reqs[0].drain_first ||
					(!in_valid && owed_statuses.size() == 0))) begin
				next_req = pending_reqs.pop_front();
				in_valid   <= 1'b1;
				kind       <= next_req.kind;
				actor_id   <= next_req.actor;
				subject_id <= next_req.subject;
				perm_bits  <= next_req.perms;
				if (burst_left <= 1) begin
					// A quarter of the bursts run straight into the next one.
					burst_left = $urandom_range(1, 12);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: out_ready follows one of three moods, drawn anew whenever the
	// current one runs out: always ready, coin toss, or mostly stalled.
	// ------------------------------------------------------------------
	int stall_mode;
	int stall_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_mode = 0;
			stall_left = 0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_left = $urandom_range(20, 120);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Monitor. Returned statuses are compared first, so a status leaving at the
	// same edge as a new request arrives is always matched with an older one.
	// ------------------------------------------------------------------
	owed_status_t oldest;
	acl_request_t seen_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_used  = 0;
			shadow_owner = 16'd1;
			owed_statuses.delete();
		end else begin
			if (out_valid && out_ready) begin
				statuses_seen[status]++;
				if (owed_statuses.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_MAX)
						$display("status %0d returned with no request outstanding", status);
				end else begin
					oldest = owed_statuses.pop_front();
					if (status !== oldest.status) begin
						error_count++;
						if (error_count <= REPORT_MAX)
							$display("status mismatch: kind %0d actor %h subject %h perms %h: expected %0d, got %0d",
								oldest.req.kind, oldest.req.actor, oldest.req.subject,
								oldest.req.perms, oldest.status, status);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				shadow_owner = cfg_data;
			if (in_valid && in_ready) begin
				seen_req.kind        = kind;
				seen_req.actor       = actor_id;
				seen_req.subject     = subject_id;
				seen_req.perms       = perm_bits;
				seen_req.drain_first = 1'b0;
				kinds_sent[kind]++;
				oldest.req    = seen_req;
				oldest.status = acl_outcome(seen_req);
				owed_statuses.push_back(oldest);
			end
		end
	end

	// Watchdog for a block that hangs or loses a status.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d statuses still owed",
				cycle_count, owed_statuses.size());
			$display("delegated_acl_table_core_tb failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers. Requests are queued at the falling edge, away from the
	// driver, which only touches the queue on the rising edge.
	// ------------------------------------------------------------------
	task automatic queue_req(logic [1:0] k, logic [ID_BITS-1:0] actor,
			logic [ID_BITS-1:0] subject, logic [PERM_W-1:0] perms);
		acl_request_t req;
		req.kind        = k;
		req.actor       = actor;
		req.subject     = subject;
		req.perms       = perms;
		req.drain_first = next_drain;
		next_drain      = 1'b0;
		pending_reqs.push_back(req);
	endtask

	// Waits until every request has gone in and every status has come out.
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || owed_statuses.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Writes the owner register; only ever called while the block is quiet.
	task automatic write_owner(logic [ID_BITS-1:0] owner);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= owner;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid  <= 1'b0;
		stim_owner = owner;
		owner_writes++;
		@(negedge clk);
	endtask

	// Mostly a small pool of users so that requests meet each other in the
	// table, with the empty id, the owner and the odd full-range id mixed in.
	function automatic logic [ID_BITS-1:0] pick_user(int owner_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < owner_pct)
			return stim_owner;
		if (roll < owner_pct + 6)
			return '0;
		if (roll < 88)
			return ID_BITS'($urandom_range(2, 25));
		if (roll < 94)
			return '1;
		return ID_BITS'($urandom);
	endfunction

	function automatic logic [PERM_W-1:0] pick_perms();
		if ($urandom_range(0, 9) == 0)
			return '0;
		return PERM_W'($urandom_range(1, 15));
	endfunction

	function automatic logic [1:0] pick_kind();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			return KIND_CHECK;
		if (roll < 75)
			return KIND_GRANT;
		if (roll < 95)
			return KIND_REVOKE;
		return KIND_UNUSED;
	endfunction

	// Queues about count requests. Most come as well-formed sequences: the
	// owner filling the table, or the owner handing share rights to one user
	// who passes some on, followed by checks and revokes. The rest is noise.
	task automatic queue_phase(int count);
		int                 made;
		int                 roll;
		int                 base;
		logic [ID_BITS-1:0] deputy;
		logic [ID_BITS-1:0] leaf;
		logic [PERM_W-1:0]  deputy_perms;
		made = 0;
		while (made < count) begin
			// A pause asked for by the caller is kept for the first request.
			next_drain = next_drain || ($urandom_range(0, 11) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 12) begin
				// Enough distinct grants to overflow the table.
				base = $urandom_range(0, 23);
				for (int i = 0; i < MAX_ENTRIES + 2; i++)
					queue_req(KIND_GRANT, stim_owner, ID_BITS'(2 + (base + i) % 24),
						PERM_W'($urandom_range(1, 15)));
				made += MAX_ENTRIES + 2;
			end else if (roll < 50) begin
				deputy       = ID_BITS'($urandom_range(2, 25));
				leaf         = ID_BITS'($urandom_range(2, 25));
				deputy_perms = PERM_W'($urandom_range(0, 15)) | PERM_W'(1 << PERM_SHARE);
				queue_req(KIND_GRANT, stim_owner, deputy, deputy_perms);
				// Half the time the deputy stays within its own rights.
				queue_req(KIND_GRANT, deputy, leaf, ($urandom_range(0, 1) != 0) ?
					(pick_perms() & deputy_perms) : pick_perms());
				queue_req(KIND_CHECK, '0, leaf, PERM_W'($urandom_range(0, 15)));
				queue_req(KIND_CHECK, ID_BITS'($urandom), deputy, PERM_W'($urandom_range(0, 15)));
				made += 4;
				if ($urandom_range(0, 1) != 0) begin
					queue_req(KIND_REVOKE, ($urandom_range(0, 2) == 0) ? stim_owner :
						(($urandom_range(0, 1) != 0) ? deputy : pick_user(10)), leaf, pick_perms());
					made++;
				end
				if ($urandom_range(0, 2) == 0) begin
					queue_req(KIND_REVOKE, stim_owner, deputy, pick_perms());
					made++;
				end
			end else begin
				queue_req(pick_kind(), pick_user(40), pick_user(10), pick_perms());
				made++;
			end
		end
	endtask

	// Hand-picked requests against owner 1 with an empty table.
	task automatic queue_directed();
		queue_req(KIND_CHECK,  16'd1,    16'd1,    4'hF); // owner needs no entry
		queue_req(KIND_CHECK,  16'd0,    16'd2,    4'hF); // unknown user
		queue_req(KIND_CHECK,  16'd0,    16'd0,    4'h0); // empty id, empty mask
		queue_req(KIND_GRANT,  16'd1,    16'd0,    4'hF); // empty subject
		queue_req(KIND_GRANT,  16'd1,    16'd2,    4'h0); // empty mask
		queue_req(KIND_GRANT,  16'd3,    16'd2,    4'h1); // grantor without an entry
		queue_req(KIND_GRANT,  16'd1,    16'd2,    4'h3);
		queue_req(KIND_GRANT,  16'd2,    16'd3,    4'h1); // grantor lacks share
		queue_req(KIND_GRANT,  16'd1,    16'd2,    4'h7); // rewrite an existing entry
		queue_req(KIND_GRANT,  16'd2,    16'd3,    4'h8); // would widen the grantor
		queue_req(KIND_GRANT,  16'd2,    16'd3,    4'h5);
		queue_req(KIND_GRANT,  16'd2,    16'd1,    4'hF); // grant to the owner
		queue_req(KIND_CHECK,  16'd0,    16'd3,    4'h0);
		queue_req(KIND_CHECK,  16'd0,    16'd3,    4'h2);
		queue_req(KIND_CHECK,  16'hFFFF, 16'd3,    4'h5);
		queue_req(KIND_REVOKE, 16'd2,    16'd1,    4'h0); // the owner cannot be revoked
		queue_req(KIND_REVOKE, 16'd4,    16'd3,    4'h0); // neither owner nor granter
		queue_req(KIND_REVOKE, 16'd2,    16'd9,    4'h0);
		queue_req(KIND_GRANT,  16'd1,    16'hFFFF, 4'hF);
		queue_req(KIND_CHECK,  16'd0,    16'hFFFF, 4'hF);
		queue_req(KIND_REVOKE, 16'd2,    16'd3,    4'h0); // by the granter, mid-table
		queue_req(KIND_REVOKE, 16'd1,    16'd2,    4'h0); // by the owner
		queue_req(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 4'hF);
		queue_req(KIND_CHECK,  16'd0,    16'd3,    4'h1);
		queue_req(KIND_REVOKE, 16'hFFFF, 16'hFFFF, 4'hF);
	endtask

	// ------------------------------------------------------------------
	// Run sequence. The owner register moves through both extremes and two
	// other values; the table carries over from one owner to the next, so a
	// former owner or an entry holder may become the owner.
	// ------------------------------------------------------------------
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		write_owner(16'd1);
		queue_directed();
		wait_quiet();

		queue_phase(150);
		// One pause partway through, waiting for every status before going on.
		next_drain = 1'b1;
		queue_phase(10);
		wait_quiet();

		write_owner(16'hFFFF);
		queue_phase(150);
		wait_quiet();

		write_owner(ID_BITS'($urandom_range(2, 25)));
		queue_phase(150);
		wait_quiet();

		write_owner(ID_BITS'($urandom_range(1, 65535)));
		queue_phase(140);
		wait_quiet();

		repeat (50) @(posedge clk);
		$display("requests: %0d check, %0d grant, %0d revoke, %0d unused kind; %0d owner writes",
			kinds_sent[KIND_CHECK], kinds_sent[KIND_GRANT], kinds_sent[KIND_REVOKE],
			kinds_sent[KIND_UNUSED], owner_writes);
		$display("statuses: %0d ok, %0d not found, %0d denied, %0d invalid, %0d full; %0d errors",
			statuses_seen[ST_OK], statuses_seen[ST_NOT_FOUND], statuses_seen[ST_DENIED],
			statuses_seen[ST_INVALID], statuses_seen[ST_FULL], error_count);
		if (error_count == 0) begin
			$display("delegated_acl_table_core_tb passed");
		end else begin
			$display("delegated_acl_table_core_tb failed");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/acl_pkg.sv
hw/rtl/acl_ram.sv
hw/rtl/delegated_acl_table_core.sv
dv/delegated_acl_table_core_tb.sv
